// File: rtl/kele_pkg.sv
// Package for the key edge line editor: shared constants, command and result types.
// Used by kele_front, kele_cmd_fifo, kele_back and the top level.
package kele_pkg;

  localparam int MAX_CAPACITY_DEF = 64;
  localparam int CMD_QUEUE_DEPTH  = 4;

  localparam logic [6:0] CAPACITY_RESET = 7'd64;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    EV_IDLE    = 2'd0,
    EV_CHANGED = 2'd1,
    EV_ENTER   = 2'd2,
    EV_ESCAPE  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_ESCAPE,
    CMD_ENTER,
    CMD_ERASE,
    CMD_TOGGLE,
    CMD_INSERT,
    CMD_NOP,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  key;
    logic [5:0]  idx;
  } cmd_t;

  typedef struct packed {
    event_e      ev;
    logic [5:0]  len;
    logic [5:0]  cur;
    logic        reveal;
    logic [7:0]  rchar;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SHIFT,
    B_LAST,
    B_PUT,
    B_READ
  } back_state_e;

endpackage

// File: rtl/kele_front.sv
// Front end: accepts input transactions, edge-detects the keys and classifies each
// item into one editor command. Depends on kele_pkg.
module kele_front
  import kele_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] escape_down, [1] enter_down, [2] backspace_down, [3] fn_down,
  // [4] shift_down, [12:5] printable_key, [18:13] read_index, [23:19] zero
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,  // op
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  logic       esc, ent, bs, fn, sh;
  logic [7:0] key;
  logic [5:0] idx;
  logic       accept;

  logic       last_esc_q, last_esc_d;
  logic       last_ent_q, last_ent_d;
  logic       last_bs_q, last_bs_d;
  logic       last_fn_q, last_fn_d;
  logic [7:0] last_key_q, last_key_d;

  logic esc_edge, ent_edge, bs_edge, fn_edge, key_edge, printable;

  assign esc = s_axis_tdata_i[0];
  assign ent = s_axis_tdata_i[1];
  assign bs  = s_axis_tdata_i[2];
  assign fn  = s_axis_tdata_i[3];
  assign sh  = s_axis_tdata_i[4];
  assign key = s_axis_tdata_i[12:5];
  assign idx = s_axis_tdata_i[18:13];

  assign s_axis_tready_o = cmd_ready_i;
  assign cmd_valid_o     = s_axis_tvalid_i;
  assign accept          = s_axis_tvalid_i && cmd_ready_i;

  assign esc_edge  = esc && !last_esc_q;
  assign ent_edge  = ent && !last_ent_q;
  assign bs_edge   = bs && !last_bs_q;
  assign fn_edge   = fn && !last_fn_q;
  assign key_edge  = (key != KEY_NONE) && (key != last_key_q);
  assign printable = (key >= KEY_SPACE) && (key < KEY_DEL);

  always_comb begin
    cmd_o.key  = key;
    cmd_o.idx  = idx;
    cmd_o.kind = CMD_IDLE;
    if (s_axis_tuser_i) begin
      cmd_o.kind = CMD_READ;
    end else if (esc_edge) begin
      cmd_o.kind = CMD_ESCAPE;
    end else if (ent_edge) begin
      cmd_o.kind = CMD_ENTER;
    end else if (bs_edge) begin
      cmd_o.kind = CMD_ERASE;
    end else if (fn_edge) begin
      cmd_o.kind = CMD_TOGGLE;
    end else if (key_edge) begin
      // shift plus a new space toggles reveal instead of typing
      if (key == KEY_SPACE && sh) begin
        cmd_o.kind = CMD_TOGGLE;
      end else if (printable) begin
        cmd_o.kind = CMD_INSERT;
      end else begin
        cmd_o.kind = CMD_NOP;
      end
    end
  end

  // every tick records all keys; reads leave the edge memory alone
  always_comb begin
    last_esc_d = last_esc_q;
    last_ent_d = last_ent_q;
    last_bs_d  = last_bs_q;
    last_fn_d  = last_fn_q;
    last_key_d = last_key_q;
    if (accept && !s_axis_tuser_i) begin
      last_esc_d = esc;
      last_ent_d = ent;
      last_bs_d  = bs;
      last_fn_d  = fn;
      last_key_d = key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_esc_q <= 1'b0;
      last_ent_q <= 1'b0;
      last_bs_q  <= 1'b0;
      last_fn_q  <= 1'b0;
      last_key_q <= KEY_NONE;
    end else begin
      last_esc_q <= last_esc_d;
      last_ent_q <= last_ent_d;
      last_bs_q  <= last_bs_d;
      last_fn_q  <= last_fn_d;
      last_key_q <= last_key_d;
    end
  end

endmodule

// File: rtl/kele_cmd_fifo.sv
// Short command queue between front and back end of the line editor.
// Depends on kele_pkg for cmd_t and the queue depth.
module kele_cmd_fifo
  import kele_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);

  cmd_t             slot_q [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != (PTR_W + 1)'(CMD_QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = slot_q[rd_q];

  always_comb begin
    wr_d   = push ? wr_q + 1'b1 : wr_q;
    rd_d   = pop ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

// File: rtl/kele_back.sv
// Back end: carries out editor commands on the line store (single-port write,
// registered read), shifts the tail one slot per cycle, holds the result register.
// Depends on kele_pkg.
module kele_back
  import kele_pkg::*;
#(
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [6:0] cfg_data_i,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  cmd_t       pop_cmd_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o
);

  localparam int IDX_W = $clog2(MAX_CAPACITY);
  localparam int LEN_W = (IDX_W > 7) ? IDX_W : 7;
  localparam int CMP_W = LEN_W + 1;

  back_state_e state_q, state_d;

  logic [7:0]       mem [MAX_CAPACITY];
  logic [7:0]       rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;

  logic [6:0]       cap_q;
  logic [LEN_W-1:0] len_q, len_d, cur_q, cur_d, cnt_q, cnt_d;
  logic             reveal_q, reveal_d;
  cmd_t             cmd_q, cmd_d;
  logic [IDX_W-1:0] src_q, src_d, dst_q, dst_d, wdst_q, wdst_d;
  logic             wpend_q, wpend_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             take, finish, full, cur_zero, no_tail;
  logic [CMP_W-1:0] cap_ext, max_ext, use_cap;
  logic [LEN_W-1:0] pop_idx, rd_idx, cur_dec, len_dec;
  event_e           ev;
  logic [7:0]       rchar;

  assign cap_ext  = CMP_W'(cap_q);
  assign max_ext  = CMP_W'(MAX_CAPACITY);
  assign use_cap  = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign full     = (CMP_W'(len_q) + CMP_W'(1)) >= use_cap;
  assign cur_zero = (cur_q == '0);
  assign no_tail  = (len_q == cur_q);
  assign cur_dec  = cur_q - 1'b1;
  assign len_dec  = len_q - 1'b1;
  assign pop_idx  = LEN_W'(pop_cmd_i.idx);
  assign rd_idx   = LEN_W'(cmd_q.idx);

  assign take        = (state_q == B_IDLE) && pop_valid_i && !out_valid_q;
  assign pop_ready_o = take;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (take) begin
          unique case (pop_cmd_i.kind)
            CMD_READ: state_d = B_READ;
            CMD_ERASE: begin
              if (!cur_zero && !no_tail) state_d = B_SHIFT;
            end
            CMD_INSERT: begin
              if (!full) state_d = no_tail ? B_PUT : B_SHIFT;
            end
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_SHIFT: begin
        if (cnt_q == LEN_W'(1)) state_d = B_LAST;
      end
      B_LAST:  state_d = (cmd_q.kind == CMD_ERASE) ? B_IDLE : B_PUT;
      B_PUT:   state_d = B_IDLE;
      B_READ:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    len_d     = len_q;
    cur_d     = cur_q;
    reveal_d  = reveal_q;
    cnt_d     = cnt_q;
    src_d     = src_q;
    dst_d     = dst_q;
    cmd_d     = cmd_q;
    wpend_d   = 1'b0;
    wdst_d    = wdst_q;
    mem_we    = wpend_q;
    mem_waddr = wdst_q;
    mem_wdata = rdata_q;
    mem_raddr = src_q;
    finish    = 1'b0;
    ev        = EV_IDLE;
    rchar     = '0;
    unique case (state_q)
      B_IDLE: begin
        if (take) begin
          cmd_d = pop_cmd_i;
          unique case (pop_cmd_i.kind)
            CMD_READ: mem_raddr = pop_idx[IDX_W-1:0];
            CMD_ESCAPE: begin
              ev     = EV_ESCAPE;
              finish = 1'b1;
            end
            CMD_ENTER: begin
              ev     = EV_ENTER;
              finish = 1'b1;
            end
            CMD_TOGGLE: begin
              reveal_d = ~reveal_q;
              ev       = EV_CHANGED;
              finish   = 1'b1;
            end
            CMD_NOP: begin
              ev     = EV_CHANGED;
              finish = 1'b1;
            end
            CMD_ERASE: begin
              ev = EV_CHANGED;
              if (cur_zero) begin
                finish = 1'b1;
              end else if (no_tail) begin
                cur_d  = cur_dec;
                len_d  = len_dec;
                finish = 1'b1;
              end else begin
                // pull the tail down: read slot i+1, write slot i
                src_d = cur_q[IDX_W-1:0];
                dst_d = cur_dec[IDX_W-1:0];
                cnt_d = len_q - cur_q;
              end
            end
            CMD_INSERT: begin
              ev = EV_CHANGED;
              if (full) begin
                finish = 1'b1;
              end else if (!no_tail) begin
                // push the tail up from the end: read slot i-1, write slot i
                src_d = len_dec[IDX_W-1:0];
                dst_d = len_q[IDX_W-1:0];
                cnt_d = len_q - cur_q;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      B_SHIFT: begin
        mem_raddr = src_q;
        wpend_d   = 1'b1;
        wdst_d    = dst_q;
        cnt_d     = cnt_q - 1'b1;
        if (cmd_q.kind == CMD_ERASE) begin
          src_d = src_q + 1'b1;
          dst_d = dst_q + 1'b1;
        end else begin
          src_d = src_q - 1'b1;
          dst_d = dst_q - 1'b1;
        end
      end
      B_LAST: begin
        // last shifted byte is written here by the pending write
        if (cmd_q.kind == CMD_ERASE) begin
          cur_d  = cur_dec;
          len_d  = len_dec;
          ev     = EV_CHANGED;
          finish = 1'b1;
        end
      end
      B_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q[IDX_W-1:0];
        mem_wdata = cmd_q.key;
        len_d     = len_q + 1'b1;
        cur_d     = cur_q + 1'b1;
        ev        = EV_CHANGED;
        finish    = 1'b1;
      end
      B_READ: begin
        if (rd_idx < len_q) rchar = rdata_q;
        finish = 1'b1;
      end
      default: ;
    endcase

    out_valid_d = out_valid_q && !res_ready_i;
    res_d       = res_q;
    if (finish) begin
      out_valid_d  = 1'b1;
      res_d.ev     = ev;
      res_d.len    = len_d[5:0];
      res_d.cur    = cur_d[5:0];
      res_d.reveal = reveal_d;
      res_d.rchar  = rchar;
    end
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    cnt_q  <= cnt_d;
    wdst_q <= wdst_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cap_q       <= CAPACITY_RESET;
      len_q       <= '0;
      cur_q       <= '0;
      reveal_q    <= 1'b0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      reveal_q    <= reveal_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  a_cursor_in_text : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q)
    else $error("cursor beyond text length");

  a_shift_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SHIFT) |-> (cnt_q != '0))
    else $error("shift running with zero count");

  a_put_responds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_PUT) |=> out_valid_q)
    else $error("insert finished without a result");

  a_len_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |->
      ((len_q == $past(len_q) + 1'b1) || (len_q + 1'b1 == $past(len_q))))
    else $error("length changed by more than one");

endmodule

// File: rtl/key_edge_line_editor.sv
// Top level of the key edge line editor: front end, command queue, back end.
// Depends on kele_pkg, kele_front, kele_cmd_fifo and kele_back.
//
// Usage: one input transaction per keyboard tick (tuser = 0) or per character
// read (tuser = 1, read_index in tdata). Every input transaction gives exactly
// one result transaction on the master side: event, length, cursor, reveal flag
// and the character read (zero for ticks and at or past the length).
// The capacity register is written on the cfg channel (always ready); the user
// must write it only while the block is idle (not enforced); reset value 64.
// Flow: the front classifies in the accepting cycle, the command is queued, and
// the back end finishes ticks that need no store access in B_IDLE as it takes
// them; reads pass B_READ, an insert at the end of the text passes B_PUT, and an
// erase or insert with a tail runs B_SHIFT to move the tail, then B_LAST, then
// for an insert B_PUT. The tail moves one slot per cycle through the single write
// port of the line store; the back end handles one command at a time.
// Reset clears length, cursor, reveal and edge memory and sets capacity to 64;
// the line store is not cleared (only data of written slots reaches the output).
// When the receiver stalls the result is held, up to four further items are
// queued, then s_axis_tready_o drops.
module key_edge_line_editor
  import kele_pkg::*;
#(
  parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] escape_down, [1] enter_down, [2] backspace_down, [3] fn_down,
  // [4] shift_down, [12:5] printable_key, [18:13] read_index, [23:19] zero
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,  // op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] event_res, [7:2] text_length, [13:8] cursor_position,
  // [14] reveal_on, [22:15] read_char, [23] zero
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i      // buffer_capacity
);

  logic cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t cmd, q_cmd;
  res_t res;

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {1'b0, res.rchar, res.reveal, res.cur, res.len, res.ev};

  kele_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  kele_cmd_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_cmd_i   (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  kele_back #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_cmd_i   (q_cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

endmodule
